### src/cone_point_project_zbuffer_defines.svh
// assertion macros shared by the cone projector checker
`ifndef CONE_POINT_PROJECT_ZBUFFER_DEFINES_SVH
`define CONE_POINT_PROJECT_ZBUFFER_DEFINES_SVH

// same-cycle implication
`define CPZ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CPZ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/cpz_pkg.sv
// types and constants shared by the cone projector modules
package cpz_pkg;

   localparam int CSR_IDX_W = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COS_A           = 4'd0,
      CSR_SIN_A           = 4'd1,
      CSR_RADIUS          = 4'd2,
      CSR_HALF_LENGTH     = 4'd3,
      CSR_RADIUS_STEP     = 4'd4,
      CSR_FIELD_OF_VIEW   = 4'd5,
      CSR_HORIZ_STRETCH   = 4'd6,
      CSR_VIEWER_DISTANCE = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] cos_a;
      logic signed [15:0] sin_a;
      logic [14:0]        radius;
      logic [6:0]         half_length;
      logic [14:0]        radius_step;
      logic [15:0]        field_of_view;
      logic [11:0]        horiz_stretch;
      logic [14:0]        viewer_distance;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      cos_a:           16'sd16384,
      sin_a:           16'sd0,
      radius:          15'd2560,
      half_length:     7'd10,
      radius_step:     15'd64,
      field_of_view:   16'd12800,
      horiz_stretch:   12'd512,
      viewer_distance: 15'd5120
   };

   // one queued item, already classified by the front end
   typedef struct packed {
      logic               action;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic signed [15:0] point_z;
      logic [7:0]         slice_number;
      logic [10:0]        clear_index;
      logic               clear_ok;
      logic               bottom;
   } item_type;

   localparam logic ACTION_PLOT  = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   localparam longint ROT_LIMIT      = 262143;
   localparam longint ZINV_SAT_DEPTH = 256;
   localparam logic [15:0] ZINV_MAX  = 16'hFFFF;

endpackage

### src/cpz_front.sv
// front end: unpacks request transactions, classifies them and feeds the queue
module cpz_front
   import cpz_pkg::*;
#(
   parameter int STORE_SIZE = 1920
)
(
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic [6:0]  half_length,
   input  logic        clearing,
   input  logic        q_full,
   output logic        push,
   output item_type    push_item
);

   logic signed [15:0] z;
   logic [16:0]        z_abs;
   logic [16:0]        z_rnd;
   logic [8:0]         r_mag;

   assign req_tready = !q_full && !clearing;
   assign push       = req_tvalid && req_tready;

   assign z     = req_tdata[47:32];
   assign z_abs = z[15] ? (17'd0 - {z[15], z}) : {1'b0, z};
   assign z_rnd = z_abs + 17'd128;
   assign r_mag = z_rnd[16:8];

   always_comb begin
      push_item.action       = req_tuser[0];
      push_item.point_x      = req_tdata[15:0];
      push_item.point_y      = req_tdata[31:16];
      push_item.point_z      = z;
      push_item.slice_number = req_tdata[55:48];
      push_item.clear_index  = req_tdata[66:56];
      push_item.clear_ok     = (32'(req_tdata[66:56]) < 32'(STORE_SIZE));
      // rounded z must equal minus half_length
      if (half_length == 7'd0) begin
         push_item.bottom = (r_mag == 9'd0);
      end else begin
         push_item.bottom = z[15] && (r_mag == {2'b0, half_length});
      end
   end

endmodule

### src/cpz_queue.sv
// two-entry queue between the front end and the back end
module cpz_queue
   import cpz_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output item_type head
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

### src/cpz_back.sv
// back end: sequencer with shared multiplier, divider, depth store and result register
module cpz_back
   import cpz_pkg::*;
#(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 24
)
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_valid,
   input  item_type    q_head,
   output logic        q_pop,
   output logic        clearing,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic [0:0]  rsp_tuser
);

   localparam int STORE_SIZE = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int AW         = $clog2(STORE_SIZE);
   localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_SIZE - 1);
   localparam logic signed [63:0] COL_BIAS  = 64'(SCREEN_COLUMNS / 2) <<< 40;
   localparam logic signed [63:0] ROW_BIAS  = 64'(SCREEN_ROWS / 2) <<< 32;
   localparam logic signed [63:0] STORE_END = 64'(STORE_SIZE);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_RAD, ST_ROT, ST_DIV, ST_PROJ, ST_READ, ST_DONE
   } state_type;

   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_mode_type;
   typedef enum logic [1:0] {SH_0, SH_14, SH_32} acc_sh_type;

   state_type          state_ff;
   logic [4:0]         step_ff;
   logic [AW-1:0]      clr_cnt_ff;
   item_type           item_ff;
   logic signed [53:0] prod_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] acc_in;
   logic signed [31:0] cc_ff, cs_ff, ss_ff;
   logic signed [51:0] u_ff;
   logic signed [24:0] lim_ff;
   logic signed [18:0] rx_ff, ry_ff;
   logic [21:0]        depth_ff;
   logic [21:0]        rem_ff;
   logic [15:0]        zinv_ff;
   logic [31:0]        p1_ff;
   logic signed [19:0] rowy_ff;
   logic signed [24:0] colx_ff;
   logic [AW-1:0]      idx_ff;
   logic               res_written_ff;
   logic [10:0]        res_index_ff;
   logic               res_glyph_ff;
   logic [15:0]        res_depth_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;
   logic               rsp_user_ff;

   logic [15:0]        mem [STORE_SIZE];
   logic [15:0]        mem_rd_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_wa;
   logic [15:0]        mem_wd;

   logic signed [19:0] mul_a;
   logic signed [33:0] mul_b;
   acc_mode_type       acc_mode;
   acc_sh_type         acc_sh;
   logic signed [63:0] prod_ext;
   logic signed [63:0] prod_sh;

   logic signed [19:0] xa, ya, za, nxa, nya, yza, ca, sa;
   logic signed [33:0] xb, yb, cb, ccb, csb, ssb, u_lo_b, u_hi_b, p1_b;
   logic signed [63:0] idx_calc;
   logic               idx_ok;
   logic signed [63:0] rz;
   logic [22:0]        div_t;
   logic               div_ge;
   logic               out_free;

   function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] v,
                                                      input int n);
      logic signed [63:0] bias;
      bias = (64'sd1 <<< n) - 64'sd1;
      if (v < 0) begin
         return (v + bias) >>> n;
      end
      return v >>> n;
   endfunction

   function automatic logic signed [18:0] sat_rot(input logic signed [63:0] v);
      if (v > ROT_LIMIT) begin
         return 19'(ROT_LIMIT);
      end
      if (v < -ROT_LIMIT) begin
         return 19'(-ROT_LIMIT);
      end
      return 19'(v);
   endfunction

   assign clearing = (state_ff == ST_CLEAR);
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

   // operand extensions
   assign xa  = {{4{item_ff.point_x[15]}}, item_ff.point_x};
   assign ya  = {{4{item_ff.point_y[15]}}, item_ff.point_y};
   assign za  = {{4{item_ff.point_z[15]}}, item_ff.point_z};
   assign nxa = -xa;
   assign nya = -ya;
   assign yza = ya - za;
   assign ca  = {{4{cfg.cos_a[15]}}, cfg.cos_a};
   assign sa  = {{4{cfg.sin_a[15]}}, cfg.sin_a};
   assign xb  = {{18{item_ff.point_x[15]}}, item_ff.point_x};
   assign yb  = {{18{item_ff.point_y[15]}}, item_ff.point_y};
   assign cb  = {{18{cfg.cos_a[15]}}, cfg.cos_a};
   assign ccb = {{2{cc_ff[31]}}, cc_ff};
   assign csb = {{2{cs_ff[31]}}, cs_ff};
   assign ssb = {{2{ss_ff[31]}}, ss_ff};
   // wide operand split into unsigned low word and signed high part
   assign u_lo_b = {2'b00, u_ff[31:0]};
   assign u_hi_b = {{14{u_ff[51]}}, u_ff[51:32]};
   assign p1_b   = {2'b00, p1_ff};

   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      acc_mode = ACC_HOLD;
      acc_sh   = SH_0;
      case (state_ff)
         ST_RAD: begin
            case (step_ff)
               5'd0: begin
                  mul_a = {12'd0, item_ff.slice_number};
                  mul_b = {19'd0, cfg.radius_step};
               end
               5'd1: begin
                  mul_a = xa;
                  mul_b = xb;
               end
               5'd2: begin
                  mul_a = ya;
                  mul_b = yb;
                  acc_mode = ACC_LOAD;
               end
               5'd3: begin
                  mul_a = {4'd0, lim_ff[15:0]};
                  mul_b = {18'd0, lim_ff[15:0]};
                  acc_mode = ACC_ADD;
               end
               default: ;
            endcase
         end
         ST_ROT: begin
            case (step_ff)
               5'd0: begin mul_a = ca; mul_b = cb; end
               5'd1: begin mul_a = ca; mul_b = {{18{cfg.sin_a[15]}}, cfg.sin_a}; end
               5'd2: begin mul_a = sa; mul_b = {{18{cfg.sin_a[15]}}, cfg.sin_a}; end
               5'd3: begin mul_a = ya; mul_b = csb; end
               5'd4: begin mul_a = nxa; mul_b = ssb; acc_mode = ACC_LOAD; end
               5'd5: begin mul_a = xa; mul_b = ccb; acc_mode = ACC_ADD; end
               5'd6: begin
                  mul_a = yza; mul_b = csb; acc_mode = ACC_LOAD; acc_sh = SH_14;
               end
               5'd7: begin
                  mul_a = sa; mul_b = u_lo_b; acc_mode = ACC_ADD; acc_sh = SH_14;
               end
               5'd8: begin mul_a = sa; mul_b = u_hi_b; acc_mode = ACC_ADD; end
               5'd9: begin
                  mul_a = nxa; mul_b = csb; acc_mode = ACC_ADD; acc_sh = SH_32;
               end
               5'd10: begin mul_a = ya; mul_b = ccb; acc_mode = ACC_LOAD; end
               5'd11: begin mul_a = za; mul_b = {{18{cfg.sin_a[15]}}, cfg.sin_a};
                  acc_mode = ACC_ADD;
               end
               5'd12: begin
                  mul_a = xa; mul_b = csb; acc_mode = ACC_ADD; acc_sh = SH_14;
               end
               5'd13: begin mul_a = nya; mul_b = ccb; acc_mode = ACC_LOAD; end
               5'd14: begin mul_a = ya; mul_b = ssb; acc_mode = ACC_ADD; end
               5'd15: begin
                  mul_a = xa; mul_b = csb; acc_mode = ACC_LOAD; acc_sh = SH_14;
               end
               5'd16: begin
                  mul_a = za; mul_b = ccb; acc_mode = ACC_ADD; acc_sh = SH_14;
               end
               5'd17: begin
                  mul_a = sa; mul_b = u_lo_b; acc_mode = ACC_ADD; acc_sh = SH_14;
               end
               5'd18: begin mul_a = sa; mul_b = u_hi_b; acc_mode = ACC_ADD; end
               5'd19: begin acc_mode = ACC_ADD; acc_sh = SH_32; end
               default: ;
            endcase
         end
         ST_PROJ: begin
            case (step_ff)
               5'd0: begin mul_a = {4'd0, zinv_ff}; mul_b = {18'd0, cfg.field_of_view}; end
               5'd2: begin mul_a = {rx_ff[18], rx_ff}; mul_b = p1_b; end
               5'd3: begin
                  mul_a = -{ry_ff[18], ry_ff}; mul_b = p1_b; acc_mode = ACC_LOAD;
               end
               5'd4: acc_mode = ACC_LOAD;
               5'd5: begin mul_a = {8'd0, cfg.horiz_stretch}; mul_b = u_lo_b; end
               5'd6: begin
                  mul_a = {8'd0, cfg.horiz_stretch}; mul_b = u_hi_b; acc_mode = ACC_LOAD;
               end
               5'd7: begin
                  mul_a = rowy_ff; mul_b = 34'(SCREEN_COLUMNS);
                  acc_mode = ACC_ADD; acc_sh = SH_32;
               end
               5'd8: acc_mode = ACC_LOAD;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign prod_ext = {{10{prod_ff[53]}}, prod_ff};

   always_comb begin
      case (acc_sh)
         SH_14:   prod_sh = prod_ext <<< 14;
         SH_32:   prod_sh = prod_ext <<< 32;
         default: prod_sh = prod_ext;
      endcase
      case (acc_mode)
         ACC_LOAD: acc_in = prod_sh;
         ACC_ADD:  acc_in = acc_ff + prod_sh;
         default:  acc_in = acc_ff;
      endcase
   end

   assign idx_calc = acc_ff + {{39{colx_ff[24]}}, colx_ff};
   assign idx_ok   = (idx_calc >= 0) && (idx_calc < STORE_END);
   assign rz       = (acc_ff >>> 42) + $signed(64'(cfg.viewer_distance));
   assign div_t    = {rem_ff, 1'b0};
   assign div_ge   = (div_t >= {1'b0, depth_ff});

   always_comb begin
      mem_we = 1'b0;
      mem_wa = clr_cnt_ff;
      mem_wd = 16'd0;
      case (state_ff)
         ST_CLEAR: mem_we = 1'b1;
         ST_IDLE: begin
            mem_we = q_valid && (q_head.action == ACTION_CLEAR) && q_head.clear_ok;
            mem_wa = AW'(q_head.clear_index);
         end
         ST_READ: begin
            mem_we = (zinv_ff > mem_rd_ff);
            mem_wa = idx_ff;
            mem_wd = zinv_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[idx_calc[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= 5'd0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               res_written_ff <= 1'b0;
               res_index_ff   <= 11'd0;
               res_glyph_ff   <= 1'b0;
               res_depth_ff   <= 16'd0;
               zinv_ff        <= 16'd0;
               step_ff        <= 5'd0;
               if (q_valid) begin
                  item_ff <= q_head;
                  if (q_head.action == ACTION_CLEAR) begin
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_RAD;
                  end
               end
            end
            ST_RAD: begin
               if (step_ff == 5'd1) begin
                  lim_ff <= $signed({10'd0, cfg.radius}) - $signed(prod_ff[24:0]);
               end
               if (step_ff == 5'd4) begin
                  step_ff <= 5'd0;
                  // squared distance against squared limit
                  if (lim_ff < 0 || acc_ff > prod_ext) begin
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_ROT;
                  end
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            ST_ROT: begin
               if (step_ff == 5'd20) begin
                  step_ff <= 5'd0;
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
               case (step_ff)
                  5'd1:  cc_ff <= prod_ff[31:0];
                  5'd2:  cs_ff <= prod_ff[31:0];
                  5'd3:  ss_ff <= prod_ff[31:0];
                  5'd6:  u_ff  <= acc_ff[51:0];
                  5'd10: rx_ff <= sat_rot(acc_ff >>> 42);
                  5'd13: ry_ff <= sat_rot(acc_ff >>> 28);
                  5'd15: u_ff  <= acc_ff[51:0];
                  5'd20: begin
                     if (rz <= 0) begin
                        state_ff <= ST_DONE;
                     end else if (rz <= ZINV_SAT_DEPTH) begin
                        zinv_ff  <= ZINV_MAX;
                        state_ff <= ST_PROJ;
                     end else begin
                        depth_ff <= rz[21:0];
                        rem_ff   <= 22'(ZINV_SAT_DEPTH);
                        state_ff <= ST_DIV;
                     end
                  end
                  default: ;
               endcase
            end
            ST_DIV: begin
               // one quotient bit a cycle
               if (div_ge) begin
                  rem_ff <= 22'(div_t - {1'b0, depth_ff});
               end else begin
                  rem_ff <= div_t[21:0];
               end
               zinv_ff <= {zinv_ff[14:0], div_ge};
               if (step_ff == 5'd15) begin
                  step_ff  <= 5'd0;
                  state_ff <= ST_PROJ;
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            ST_PROJ: begin
               if (step_ff == 5'd9) begin
                  step_ff <= 5'd0;
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
               case (step_ff)
                  5'd1: p1_ff   <= prod_ff[31:0];
                  5'd4: u_ff    <= acc_ff[51:0];
                  5'd5: rowy_ff <= 20'(trunc_shift(acc_ff + ROW_BIAS, 32));
                  5'd8: colx_ff <= 25'(trunc_shift(acc_ff + COL_BIAS, 40));
                  5'd9: begin
                     idx_ff  <= idx_calc[AW-1:0];
                     if (idx_ok) begin
                        state_ff <= ST_READ;
                     end else begin
                        state_ff <= ST_DONE;
                     end
                  end
                  default: ;
               endcase
            end
            ST_READ: begin
               if (zinv_ff > mem_rd_ff) begin
                  res_written_ff <= 1'b1;
                  res_index_ff   <= 11'(idx_ff);
                  res_glyph_ff   <= item_ff.bottom;
                  res_depth_ff   <= zinv_ff;
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= res_written_ff;
                  rsp_data_ff  <= {4'd0, res_depth_ff, res_glyph_ff, res_index_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### src/cone_point_project_zbuffer.sv
// Cone sample-point projector with a depth store.
// req channel: one transaction per sample point or clear action. tuser is the
// action (0 plot, 1 clear); tdata carries point x/y/z, slice number, clear index.
// rsp channel: exactly one transaction per request, in order. tuser is the
// written flag; tdata holds pixel index, glyph and reciprocal depth, all zero
// when nothing was written.
// csr channel: register writes by index, always ready; the user must write only
// while idle, and the block itself does not enforce it. A plot runs the radius
// test, the rotation through the shared 20x34 multiplier, the bit-serial
// reciprocal divider where needed, the projection, the depth store read and the
// result register; one item is in the back end at a time. After reset the depth
// store is cleared, one entry a cycle, over all SCREEN_COLUMNS*SCREEN_ROWS
// entries (1920 by default) with req_tready low. A two-entry queue accepts
// requests while a result waits, until it is full; when the receiver stalls the
// result register holds and the back end waits behind it.
module cone_point_project_zbuffer
   import cpz_pkg::*;
#(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 24
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // x [15:0], y [31:16], z [47:32], slice_number [55:48], clear_index [66:56]
   input  logic [71:0]          req_tdata,
   // action [0]
   input  logic [0:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // pixel_index [10:0], glyph [11], depth_value [27:12]
   output logic [31:0]          rsp_tdata,
   // written [0]
   output logic [0:0]           rsp_tuser,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   cfg_type  cfg_ff;
   logic     clearing;
   logic     q_full;
   logic     push;
   item_type push_item;
   logic     pop;
   logic     q_valid;
   item_type q_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_COS_A:           cfg_ff.cos_a           <= csr_data;
            CSR_SIN_A:           cfg_ff.sin_a           <= csr_data;
            CSR_RADIUS:          cfg_ff.radius          <= csr_data[14:0];
            CSR_HALF_LENGTH:     cfg_ff.half_length     <= csr_data[6:0];
            CSR_RADIUS_STEP:     cfg_ff.radius_step     <= csr_data[14:0];
            CSR_FIELD_OF_VIEW:   cfg_ff.field_of_view   <= csr_data;
            CSR_HORIZ_STRETCH:   cfg_ff.horiz_stretch   <= csr_data[11:0];
            CSR_VIEWER_DISTANCE: cfg_ff.viewer_distance <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   cpz_front #(
      .STORE_SIZE(SCREEN_COLUMNS * SCREEN_ROWS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .half_length(cfg_ff.half_length),
      .clearing   (clearing),
      .q_full     (q_full),
      .push       (push),
      .push_item  (push_item)
   );

   cpz_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .full     (q_full),
      .pop      (pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   cpz_back #(
      .SCREEN_COLUMNS(SCREEN_COLUMNS),
      .SCREEN_ROWS   (SCREEN_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (pop),
      .clearing  (clearing),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

### src/cpz_checker.sv
// port-level checker for the cone projector, bound to the top level
`include "cone_point_project_zbuffer_defines.svh"

module cpz_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   `CPZ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")

   `CPZ_ASSERT_NOW(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == 32'd0, "unwritten response carries data")

   `CPZ_ASSERT_NOW(a_hit_depth, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata[27:12] != 16'd0, "written response with zero depth")

   `CPZ_ASSERT_NOW(a_clear_pass, clock, reset, $past(reset), !req_tready && !rsp_tvalid, "request taken during clearing pass")

endmodule

bind cone_point_project_zbuffer cpz_checker u_cpz_checker (.*);

### sim/cone_point_project_zbuffer_tb.sv
// self-checking testbench for the cone point projector with depth store
`timescale 1ns / 1ps

module cone_point_project_zbuffer_tb;
   import cpz_pkg::*;

   localparam int COLS       = 80;
   localparam int ROWS       = 24;
   localparam int CELLS      = COLS * ROWS;
   localparam int DRAIN_WAIT = 80;

   typedef struct {
      logic               action;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] pz;
      logic [7:0]         slice;
      logic [10:0]        clr_idx;
   } point_t;

   typedef struct {
      logic        written;
      logic [10:0] pixel;
      logic        glyph;
      logic [15:0] zinv;
   } plot_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   cone_point_project_zbuffer dut (.*);

   always #1 clock = ~clock;

   cfg_type     cfg = CFG_RESET;
   logic [15:0] zdepth [CELLS];
   point_t      pending [$];
   plot_t       plots_due [$];
   point_t      cur_point;
   int          errors = 0;
   int          n_plots = 0;
   int          n_written = 0;
   int          n_glyph = 0;
   int          send_gap = 0;
   int          recv_gap = 0;
   bit          burst_mode = 0;
   bit          rsp_hold = 0;

   initial foreach (zdepth[i]) zdepth[i] = '0;

   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 19);
      if (burst_mode || r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic longint floor_sh(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint trunc_sh(longint v, int n);
      return (v >= 0) ? (v >>> n) : -((-v) >>> n);
   endfunction

   function automatic longint sat_rot(longint v);
      if (v > ROT_LIMIT) return ROT_LIMIT;
      if (v < -ROT_LIMIT) return -ROT_LIMIT;
      return v;
   endfunction

   // projects one point, or applies a clear, and updates the depth store copy
   function automatic plot_t project_point(point_t p);
      plot_t  r;
      longint x, y, z, lim, c, s, cc, cs, ss, acc, rx, ry, rz, zi, col, row, idx, rnd;
      longint fov, hs;
      r = '{1'b0, 11'd0, 1'b0, 16'd0};
      if (p.action == ACTION_CLEAR) begin
         if (p.clr_idx < CELLS) zdepth[p.clr_idx] = '0;
         return r;
      end
      x = p.px;
      y = p.py;
      z = p.pz;
      lim = longint'({1'b0, cfg.radius}) - longint'({1'b0, cfg.radius_step}) * p.slice;
      if (lim < 0 || x * x + y * y > lim * lim) return r;
      c = cfg.cos_a;
      s = cfg.sin_a;
      cc = c * c;
      cs = c * s;
      ss = s * s;
      acc = (x * cc + y * cs - z * cs) * 16384 + y * cs * s - x * ss * s;
      rx = sat_rot(floor_sh(acc, 42));
      acc = z * s * 16384 + y * cc - x * cs;
      ry = sat_rot(floor_sh(acc, 28));
      acc = (x * cs + y * ss + z * cc) * 16384 - y * cc * s + x * cs * s;
      rz = floor_sh(acc, 42) + longint'({1'b0, cfg.viewer_distance});
      if (rz <= 0) return r;
      zi = (longint'(1) << 24) / rz;
      if (zi > 65535) zi = 65535;
      fov = {1'b0, cfg.field_of_view};
      hs = {1'b0, cfg.horiz_stretch};
      col = trunc_sh(rx * fov * zi * hs + longint'(COLS / 2) * (longint'(1) << 40), 40);
      row = trunc_sh(longint'(ROWS / 2) * (longint'(1) << 32) - ry * fov * zi, 32);
      idx = col + row * COLS;
      if (idx < 0 || idx >= CELLS) return r;
      if (zi <= longint'(zdepth[idx])) return r;
      zdepth[idx] = zi[15:0];
      rnd = (z >= 0) ? (z + 128) / 256 : -((-z + 128) / 256);
      r.written = 1'b1;
      r.pixel = idx[10:0];
      r.glyph = (rnd == -longint'({1'b0, cfg.half_length}));
      r.zinv = zi[15:0];
      return r;
   endfunction

   function automatic point_t mk(logic act, int x, int y, int z, int sl, int ci);
      point_t p;
      p.action = act;
      p.px = x[15:0];
      p.py = y[15:0];
      p.pz = z[15:0];
      p.slice = sl[7:0];
      p.clr_idx = ci[10:0];
      return p;
   endfunction

   function automatic int srand(int a);
      return int'($urandom_range(0, 2 * a)) - a;
   endfunction

   // mostly points on the cone surface or inside it, some noise and clears
   function automatic point_t random_point();
      int r, lim, sl, maxsl, span, hl, z;
      r = $urandom_range(0, 99);
      if (r < 10)
         return mk(ACTION_CLEAR, 0, 0, 0, $urandom_range(0, 255), $urandom_range(0, 2047));
      if (r < 25)
         return mk(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                   $urandom_range(0, 255), $urandom_range(0, 2047));
      maxsl = (cfg.radius_step == 0) ? 255 : cfg.radius / cfg.radius_step;
      if (maxsl > 255) maxsl = 255;
      sl = $urandom_range(0, maxsl);
      lim = int'(cfg.radius) - int'(cfg.radius_step) * sl;
      span = (lim * 7) / 10;
      hl = cfg.half_length * 256;
      if ($urandom_range(0, 3) == 0) z = -hl + srand(140);
      else z = srand(hl + 256);
      if (z > 32767) z = 32767;
      if (z < -32768) z = -32768;
      return mk(ACTION_PLOT, srand(span), srand(span), z, sl, $urandom_range(0, 2047));
   endfunction

   task automatic report(string what, longint want, longint got);
      $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
      errors++;
   endtask

   // sender
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) plots_due.push_back(project_point(cur_point));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0 || pending.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_tvalid <= 1'b0;
            end else begin
               cur_point = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= cur_point.action;
               req_tdata <= {5'd0, cur_point.clr_idx, cur_point.slice, cur_point.pz,
                             cur_point.py, cur_point.px};
               send_gap = rand_gap();
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      plot_t want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (plots_due.size() == 0) begin
               report("unexpected result, written", -1, rsp_tuser[0]);
            end else begin
               want = plots_due.pop_front();
               n_plots++;
               if (want.written) n_written++;
               if (want.glyph) n_glyph++;
               if (rsp_tuser[0] !== want.written) report("written", want.written, rsp_tuser[0]);
               if (rsp_tdata[10:0] !== want.pixel) report("pixel_index", want.pixel, rsp_tdata[10:0]);
               if (rsp_tdata[11] !== want.glyph) report("glyph", want.glyph, rsp_tdata[11]);
               if (rsp_tdata[27:12] !== want.zinv) report("depth_value", want.zinv, rsp_tdata[27:12]);
               if (rsp_tdata[31:28] !== 4'd0) report("tdata padding", 0, rsp_tdata[31:28]);
            end
         end
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap = rand_gap();
         end
      end
   end

   task automatic csr_write(csr_index_type idx, logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_COS_A:           cfg.cos_a = value;
         CSR_SIN_A:           cfg.sin_a = value;
         CSR_RADIUS:          cfg.radius = value[14:0];
         CSR_HALF_LENGTH:     cfg.half_length = value[6:0];
         CSR_RADIUS_STEP:     cfg.radius_step = value[14:0];
         CSR_FIELD_OF_VIEW:   cfg.field_of_view = value;
         CSR_HORIZ_STRETCH:   cfg.horiz_stretch = value[11:0];
         CSR_VIEWER_DISTANCE: cfg.viewer_distance = value[14:0];
         default: ;
      endcase
   endtask

   task automatic write_all(cfg_type c);
      csr_write(CSR_COS_A, c.cos_a);
      csr_write(CSR_SIN_A, c.sin_a);
      csr_write(CSR_RADIUS, {1'b0, c.radius});
      csr_write(CSR_HALF_LENGTH, {9'd0, c.half_length});
      csr_write(CSR_RADIUS_STEP, {1'b0, c.radius_step});
      csr_write(CSR_FIELD_OF_VIEW, c.field_of_view);
      csr_write(CSR_HORIZ_STRETCH, {4'd0, c.horiz_stretch});
      csr_write(CSR_VIEWER_DISTANCE, {1'b0, c.viewer_distance});
   endtask

   // sampled at the falling edge so that the sender's updates have settled
   task automatic drain();
      do @(negedge clock);
      while (pending.size() != 0 || req_tvalid || plots_due.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic run_random(int count);
      repeat (count) pending.push_back(random_point());
      drain();
   endtask

   // receiver holds off long enough for the block to back up
   initial begin
      wait (!reset);
      wait (n_plots > 60);
      rsp_hold = 1;
      repeat (400) @(posedge clock);
      rsp_hold = 0;
   end

   initial begin
      cfg_type c;
      int ang [5][2] = '{'{16384, 0}, '{0, 16384}, '{-16384, 0}, '{11585, 11585},
                         '{-16384, -16384}};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_all(CFG_RESET);
      // directed points and clears with the default view
      pending.push_back(mk(ACTION_PLOT, 0, 0, 0, 0, 0));
      pending.push_back(mk(ACTION_PLOT, 0, 0, 0, 0, 0));
      pending.push_back(mk(ACTION_PLOT, 0, 0, -2560, 0, 0));
      pending.push_back(mk(ACTION_PLOT, 0, 0, -2688, 0, 0));
      pending.push_back(mk(ACTION_PLOT, 256, -256, 2560, 0, 0));
      pending.push_back(mk(ACTION_PLOT, 32767, 0, 0, 0, 0));
      pending.push_back(mk(ACTION_PLOT, -32768, -32768, -32768, 0, 0));
      pending.push_back(mk(ACTION_PLOT, 0, 0, 32767, 0, 0));
      pending.push_back(mk(ACTION_PLOT, 0, 0, 0, 255, 0));
      pending.push_back(mk(ACTION_PLOT, 0, 0, 0, 40, 0));
      pending.push_back(mk(ACTION_PLOT, 2000, 2000, -1000, 0, 0));
      pending.push_back(mk(ACTION_CLEAR, 0, 0, 0, 0, 1919));
      pending.push_back(mk(ACTION_CLEAR, 0, 0, 0, 0, 1920));
      pending.push_back(mk(ACTION_CLEAR, 0, 0, 0, 0, 2047));
      pending.push_back(mk(ACTION_CLEAR, 0, 0, 0, 0, 0));
      pending.push_back(mk(ACTION_CLEAR, 0, 0, 0, 0, 1000));
      pending.push_back(mk(ACTION_PLOT, 0, 0, 0, 0, 0));
      pending.push_back(mk(ACTION_PLOT, 0, 0, -16, 0, 0));
      drain();
      run_random(200);
      // extreme settings, a near rotated view, then random views
      for (int ph = 0; ph < 6; ph++) begin
         c = CFG_RESET;
         case (ph)
            0: begin
               c.cos_a = 16'sd16384; c.sin_a = 16'sd16384; c.radius = 15'd32767;
               c.half_length = 7'd127; c.radius_step = 15'd32767;
               c.field_of_view = 16'hFFFF; c.horiz_stretch = 12'hFFF;
               c.viewer_distance = 15'd32767;
            end
            1: begin
               c.cos_a = -16'sd16384; c.sin_a = -16'sd16384; c.radius = 15'd0;
               c.half_length = 7'd0; c.radius_step = 15'd0;
               c.field_of_view = 16'd0; c.horiz_stretch = 12'd0;
               c.viewer_distance = 15'd0;
            end
            2: begin
               c.viewer_distance = 15'd100;
               c.sin_a = 16'sd16384; c.cos_a = 16'sd0;
            end
            default: begin
               c.cos_a = 16'(ang[ph - 1][0]);
               c.sin_a = 16'(ang[ph - 1][1]);
               c.radius = 15'($urandom_range(1024, 4096));
               c.half_length = 7'($urandom_range(2, 16));
               c.radius_step = 15'($urandom_range(0, 128));
               c.field_of_view = 16'($urandom_range(2000, 20000));
               c.horiz_stretch = 12'($urandom_range(128, 1024));
               c.viewer_distance = 15'($urandom_range(1000, 8000));
            end
         endcase
         burst_mode = (ph == 3);
         write_all(c);
         run_random(ph == 1 ? 60 : 130);
      end
      burst_mode = 0;
      write_all(CFG_RESET);
      run_random(120);
      $display("covered %0d results, %0d depth writes, %0d bottom glyphs", n_plots,
               n_written, n_glyph);
      $display("over default, extreme and rotated views with clears and a long stall");
      if (errors == 0)
         $display("cone_point_project_zbuffer_tb: clean");
      else
         $display("cone_point_project_zbuffer_tb: errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout waiting for results");
      $display("cone_point_project_zbuffer_tb: errors");
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/cpz_pkg.sv
src/cpz_front.sv
src/cpz_queue.sv
src/cpz_back.sv
src/cone_point_project_zbuffer.sv
src/cpz_checker.sv
sim/cone_point_project_zbuffer_tb.sv
